>>> src/nsd_pkg.sv
// shared types and constants for the normalizing signed divider
package nsd_pkg;

   localparam int unsigned FRAC_SHIFT_W = 6;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DIVIDE,
      ST_NORM,
      ST_FINISH
   } state_type;

endpackage

>>> src/normalizing_signed_divider_core.sv
// Signed divider with a normalized quotient mantissa and fraction shift.
// One shared subtract-and-compare unit produces one quotient bit per cycle:
// restoring division on the operand magnitudes for DATA_WIDTH bits, then, when
// a remainder is left, one fraction bit at a time until the quotient magnitude
// reaches 2^(DATA_WIDTH-2) (at most 2*DATA_WIDTH-3 fraction bits). Before this
// the operands are taken; after it the normalization limit is seen reached, when
// a remainder was left, and the sign is fixed. A zero numerator or denominator
// goes from taking the operands straight to the sign fix, which waits while an
// earlier result has not been taken. req_tready is high only while the unit
// is free. The result sits in an output register, so the next transfer can be
// taken while a result waits. frac_shift keeps its low 6 bits.
module normalizing_signed_divider_core #(
   parameter int unsigned DATA_WIDTH = 32
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_tvalid,
   output logic                       req_tready,
   // numerator, denominator, zero padding
   input  logic [((2*DATA_WIDTH+7)/8)*8-1:0] req_tdata,
   output logic                       rsp_tvalid,
   input  logic                       rsp_tready,
   // quotient, frac_shift, zero padding
   output logic [((DATA_WIDTH+nsd_pkg::FRAC_SHIFT_W+7)/8)*8-1:0] rsp_tdata,
   // div_by_zero
   output logic                       rsp_tuser
);

   localparam int unsigned W      = DATA_WIDTH;
   localparam int unsigned FW     = nsd_pkg::FRAC_SHIFT_W;
   localparam int unsigned RSP_W  = ((DATA_WIDTH + FW + 7) / 8) * 8;
   localparam int unsigned CNT_W  = $clog2(DATA_WIDTH);

   localparam logic [W-1:0] MAX_POS  = {1'b0, {(W-1){1'b1}}};
   localparam logic [W-1:0] SIGN_BIT = {1'b1, {(W-1){1'b0}}};

   nsd_pkg::state_type state_ff, state_in;

   logic [W-1:0]     a_ff, a_in;
   logic [W-1:0]     b_ff, b_in;
   logic [W-1:0]     r_ff, r_in;
   logic [W-1:0]     q_ff, q_in;
   logic [FW-1:0]    n_ff, n_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             neg_ff, neg_in;
   logic             dz_ff, dz_in;

   logic [W-1:0]     rsp_q_ff, rsp_q_in;
   logic [FW-1:0]    rsp_n_ff, rsp_n_in;
   logic             rsp_dz_ff, rsp_dz_in;
   logic             rsp_valid_ff, rsp_valid_in;

   logic [W-1:0] num, den, num_mag, den_mag;
   logic         accept, out_free;

   // shared subtract-and-compare unit
   logic         step_bit;
   logic [W-1:0] r_sh, r_step, q_step;
   logic [W:0]   diff;
   logic         ge;

   assign num     = req_tdata[W-1:0];
   assign den     = req_tdata[2*W-1:W];
   assign num_mag = num[W-1] ? (~num + 1'b1) : num;
   assign den_mag = den[W-1] ? (~den + 1'b1) : den;

   assign req_tready = (state_ff == nsd_pkg::ST_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign out_free   = !rsp_valid_ff || rsp_tready;

   assign step_bit = (state_ff == nsd_pkg::ST_DIVIDE) ? a_ff[W-1] : 1'b0;
   // remainder stays below the divisor, so its top bit is always clear
   assign r_sh     = {r_ff[W-2:0], step_bit};
   assign diff     = {1'b0, r_sh} - {1'b0, b_ff};
   assign ge       = !diff[W];
   assign r_step   = ge ? diff[W-1:0] : r_sh;
   assign q_step   = {q_ff[W-2:0], ge};

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         nsd_pkg::ST_IDLE: begin
            if (accept) begin
               if (den_mag == '0 || num_mag == '0) begin
                  state_in = nsd_pkg::ST_FINISH;
               end else begin
                  state_in = nsd_pkg::ST_DIVIDE;
               end
            end
         end
         nsd_pkg::ST_DIVIDE: begin
            if (cnt_ff == '0) begin
               state_in = (r_step == '0) ? nsd_pkg::ST_FINISH : nsd_pkg::ST_NORM;
            end
         end
         nsd_pkg::ST_NORM: begin
            if (q_ff[W-1:W-2] != 2'b00) begin
               state_in = nsd_pkg::ST_FINISH;
            end
         end
         nsd_pkg::ST_FINISH: begin
            if (out_free) begin
               state_in = nsd_pkg::ST_IDLE;
            end
         end
         default: state_in = nsd_pkg::ST_IDLE;
      endcase
   end

   // datapath and result register
   always_comb begin
      a_in         = a_ff;
      b_in         = b_ff;
      r_in         = r_ff;
      q_in         = q_ff;
      n_in         = n_ff;
      cnt_in       = cnt_ff;
      neg_in       = neg_ff;
      dz_in        = dz_ff;
      rsp_q_in     = rsp_q_ff;
      rsp_n_in     = rsp_n_ff;
      rsp_dz_in    = rsp_dz_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      unique case (state_ff)
         nsd_pkg::ST_IDLE: begin
            if (accept) begin
               a_in   = num_mag;
               b_in   = den_mag;
               r_in   = '0;
               n_in   = '0;
               cnt_in = CNT_W'(W - 1);
               dz_in  = (den_mag == '0);
               if (den_mag == '0) begin
                  // saturate by numerator sign; negating the sign bit keeps it
                  q_in   = num[W-1] ? SIGN_BIT : MAX_POS;
                  neg_in = num[W-1];
               end else if (num_mag == '0) begin
                  q_in   = '0;
                  neg_in = 1'b0;
               end else begin
                  q_in   = '0;
                  neg_in = num[W-1] ^ den[W-1];
               end
            end
         end
         nsd_pkg::ST_DIVIDE: begin
            a_in   = {a_ff[W-2:0], 1'b0};
            r_in   = r_step;
            q_in   = q_step;
            cnt_in = cnt_ff - 1'b1;
         end
         nsd_pkg::ST_NORM: begin
            if (q_ff[W-1:W-2] == 2'b00) begin
               r_in = r_step;
               q_in = q_step;
               n_in = n_ff + 1'b1;
            end
         end
         nsd_pkg::ST_FINISH: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_n_in     = n_ff;
               rsp_dz_in    = dz_ff;
               if (neg_ff) begin
                  rsp_q_in = ~q_ff + 1'b1;
               end else if (q_ff > MAX_POS) begin
                  rsp_q_in = MAX_POS;
               end else begin
                  rsp_q_in = q_ff;
               end
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= nsd_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      a_ff      <= a_in;
      b_ff      <= b_in;
      r_ff      <= r_in;
      q_ff      <= q_in;
      n_ff      <= n_in;
      cnt_ff    <= cnt_in;
      neg_ff    <= neg_in;
      dz_ff     <= dz_in;
      rsp_q_ff  <= rsp_q_in;
      rsp_n_ff  <= rsp_n_in;
      rsp_dz_ff <= rsp_dz_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = RSP_W'({rsp_n_ff, rsp_q_ff});
   assign rsp_tuser  = rsp_dz_ff;

endmodule
